FILE: rtl/core/sfcc_pkg.sv
// Package with shared types, constants and the CRC-8 byte function of the frame checker.
`timescale 1ns / 1ps

package sfcc_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] FAIL_MAX = 8'hFF;

  // Position of a byte inside its three-byte word group.
  typedef enum logic [2:0] {
    SLOT_HIGH = 3'b001,
    SLOT_LOW  = 3'b010,
    SLOT_CRC  = 3'b100
  } slot_e;

  typedef struct packed {
    logic [15:0] word_value;
    logic [1:0]  word_index;
    logic        crc_ok;
    logic        frame_last;
    logic        restart_request;
    logic [7:0]  fail_count;
  } result_t;

  // One byte of the MSB-first CRC-8 with polynomial 0x31.
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

FILE: rtl/core/sfcc_in_if.sv
// Input channel carrying one received byte and its frame start flag.
`timescale 1ns / 1ps

interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

FILE: rtl/core/sfcc_out_if.sv
// Result channel carrying one checked word and the frame status.
`timescale 1ns / 1ps

interface sfcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_value;
  logic [1:0]  word_index;
  logic        crc_ok;
  logic        frame_last;
  logic        restart_request;
  logic [7:0]  fail_count;

  modport source (output valid, output word_value, output word_index, output crc_ok,
                  output frame_last, output restart_request, output fail_count,
                  input ready);
  modport sink (input valid, input word_value, input word_index, input crc_ok,
                input frame_last, input restart_request, input fail_count,
                output ready);
endinterface

FILE: rtl/core/sensor_word_frame_crc_checker.sv
// Top level of the sensor frame CRC checker: input register, frame core and result register.
`timescale 1ns / 1ps

// Checks a sensor read frame byte by byte: each word is a high byte, a low byte and a CRC-8
// byte (init 0xFF, polynomial 0x31, MSB first). On every CRC byte one result gives the word,
// its index, the pass flag, the last-of-frame flag, the consecutive failed-frame count and a
// restart request once that count exceeds the threshold set through cfg_we_i/cfg_wdata_i.
// After a failure, and after a complete frame, bytes give no result until the next
// frame_start. One byte is taken every cycle while the result register is free; a byte
// waits in the input register and its result is then loaded into the output register.
// Input stalls only while the result register is full and not taken, since the frame state
// advances with the byte that leaves the input register.
module sensor_word_frame_crc_checker #(
  parameter int WORDS_PER_FRAME = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  sfcc_in_if.sink          rx_i,
  sfcc_out_if.source       res_o
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_start_q;
  logic [7:0]        threshold_q;
  logic              out_valid_q;
  sfcc_pkg::result_t out_q;
  logic              out_free;
  logic              fire;
  logic              core_valid;
  sfcc_pkg::result_t core_res;

  assign out_free   = !out_valid_q || res_o.ready;
  assign fire       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= 8'd3;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q  <= rx_i.rx_byte;
      in_start_q <= rx_i.frame_start;
    end
  end

  sfcc_frame_core #(
    .WORDS_PER_FRAME (WORDS_PER_FRAME)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .rx_byte_i     (in_byte_q),
    .frame_start_i (in_start_q),
    .threshold_i   (threshold_q),
    .res_valid_o   (core_valid),
    .res_o         (core_res)
  );

  // The result register loads whenever it is free; a byte without a result empties it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && core_valid) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.word_value      = out_q.word_value;
  assign res_o.word_index      = out_q.word_index;
  assign res_o.crc_ok          = out_q.crc_ok;
  assign res_o.frame_last      = out_q.frame_last;
  assign res_o.restart_request = out_q.restart_request;
  assign res_o.fail_count      = out_q.fail_count;

endmodule

FILE: rtl/core/sfcc_frame_core.sv
// Frame position tracking, running CRC, word assembly and failed-frame counting.
`timescale 1ns / 1ps

module sfcc_frame_core #(
  parameter int WORDS_PER_FRAME = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 frame_start_i,
  input  logic [7:0]           threshold_i,
  output logic                 res_valid_o,
  output sfcc_pkg::result_t    res_o
);

  localparam int IDX_W = $clog2(WORDS_PER_FRAME + 1);
  localparam logic [IDX_W-1:0] IDX_DONE = IDX_W'(WORDS_PER_FRAME);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WORDS_PER_FRAME - 1);

  sfcc_pkg::slot_e  slot_q, slot_d, slot_cur;
  logic [IDX_W-1:0] widx_q, widx_d, widx_cur;
  logic             failed_q, failed_d, failed_cur;
  logic [7:0]       count_q, count_d;
  logic [15:0]      word_q, word_d;
  logic [7:0]       crc_q, crc_d;
  logic [IDX_W+1:0] widx_ext;
  logic             active;
  logic             ok;
  logic             last;
  logic [7:0]       count_inc;

  // A frame start restarts position and failure status for this very byte.
  assign slot_cur   = frame_start_i ? sfcc_pkg::SLOT_HIGH : slot_q;
  assign widx_cur   = frame_start_i ? '0 : widx_q;
  assign failed_cur = frame_start_i ? 1'b0 : failed_q;
  assign active     = !failed_cur && (widx_cur != IDX_DONE);
  assign ok         = (crc_q == rx_byte_i);
  assign last       = (widx_cur == IDX_LAST);
  assign count_inc  = (count_q == sfcc_pkg::FAIL_MAX) ? count_q : count_q + 8'd1;
  assign widx_ext   = {2'b00, widx_cur};

  always_comb begin
    slot_d      = slot_cur;
    widx_d      = widx_cur;
    failed_d    = failed_cur;
    count_d     = count_q;
    word_d      = word_q;
    crc_d       = crc_q;
    res_valid_o = 1'b0;
    res_o.word_value      = word_q;
    res_o.word_index      = widx_ext[1:0];
    res_o.crc_ok          = ok;
    res_o.frame_last      = 1'b0;
    res_o.restart_request = 1'b0;
    res_o.fail_count      = count_q;
    if (active) begin
      case (slot_cur)
        sfcc_pkg::SLOT_HIGH: begin
          word_d = {rx_byte_i, 8'h00};
          crc_d  = sfcc_pkg::crc_byte(sfcc_pkg::CRC_INIT, rx_byte_i);
          slot_d = sfcc_pkg::SLOT_LOW;
        end
        sfcc_pkg::SLOT_LOW: begin
          word_d = {word_q[15:8], rx_byte_i};
          crc_d  = sfcc_pkg::crc_byte(crc_q, rx_byte_i);
          slot_d = sfcc_pkg::SLOT_CRC;
        end
        sfcc_pkg::SLOT_CRC: begin
          res_valid_o = 1'b1;
          slot_d      = sfcc_pkg::SLOT_HIGH;
          widx_d      = widx_cur + IDX_W'(1);
          if (ok) begin
            res_o.frame_last = last;
            if (last) begin
              count_d = '0;
            end
          end else begin
            res_o.frame_last = 1'b1;
            failed_d         = 1'b1;
            count_d          = count_inc;
            if (count_inc > threshold_i) begin
              res_o.restart_request = 1'b1;
              count_d               = '0;
            end
          end
          res_o.fail_count = count_d;
        end
        default: begin
          slot_d = sfcc_pkg::SLOT_HIGH;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= sfcc_pkg::SLOT_HIGH;
      widx_q   <= '0;
      failed_q <= 1'b0;
      count_q  <= '0;
    end else if (fire_i) begin
      slot_q   <= slot_d;
      widx_q   <= widx_d;
      failed_q <= failed_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      word_q <= word_d;
      crc_q  <= crc_d;
    end
  end

endmodule
